// ----- hdl/nwta_pkg.sv -----
// ---------------------------------------------------------------------------
// nwta_pkg
// types and constants shared by the two-hop slot assigner modules
// ---------------------------------------------------------------------------
package nwta_pkg;

  // time and field widths
  localparam int TIME_W    = 32;
  localparam int PORT_W    = 5;
  localparam int PORT_CODES = 2 ** PORT_W;
  localparam int PAYLOAD_W = 11;
  localparam int CFG_W     = 16;
  localparam int SER_W     = 15;
  localparam int SUM_W     = 18;
  localparam int CFG_IDX_W = 2;

  // frame overhead in bytes and nanoseconds per byte at 1 Gb/s
  localparam logic [PAYLOAD_W:0] HDR_BYTES  = 12'd58;
  localparam int                 NS_SHIFT   = 3;

  // saturation value for all times
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] GAP_RESET = 16'd96;

  typedef struct packed {
    logic [CFG_W-1:0] switch_delay_ns;
    logic [CFG_W-1:0] link_delay_ns;
    logic [CFG_W-1:0] gap_ns;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0]    source_port;
    logic [PORT_W-1:0]    dest_port;
    logic [PAYLOAD_W-1:0] payload_bytes;
    logic [TIME_W-1:0]    deadline_ns;
  } req_t;

  typedef struct packed {
    logic [TIME_W-1:0] ingress_start_ns;
    logic [TIME_W-1:0] egress_start_ns;
    logic              meets_deadline;
  } resp_t;

endpackage

// ----- hdl/nwta_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// nwta_cfg_regs
// delay and gap registers behind a plain write port
// ---------------------------------------------------------------------------
module nwta_cfg_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nwta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nwta_pkg::CFG_W-1:0]      cfg_data,
  output nwta_pkg::cfg_t                  cfg
);

  // indexes beyond the register list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.switch_delay_ns <= '0;
      cfg.link_delay_ns   <= '0;
      cfg.gap_ns          <= nwta_pkg::GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        nwta_pkg::CFG_SWITCH_DELAY: cfg.switch_delay_ns <= cfg_data;
        nwta_pkg::CFG_LINK_DELAY:   cfg.link_delay_ns   <= cfg_data;
        nwta_pkg::CFG_GAP:          cfg.gap_ns          <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hdl/nwta_time_ram.sv -----
// ---------------------------------------------------------------------------
// nwta_time_ram
// per-link free time memory, one read and one write port, registered read
// ---------------------------------------------------------------------------
module nwta_time_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rd_en,
  input  logic [AW-1:0]                   rd_addr,
  output logic [nwta_pkg::TIME_W-1:0]     rd_data,
  input  logic                            wr_en,
  input  logic [AW-1:0]                   wr_addr,
  input  logic [nwta_pkg::TIME_W-1:0]     wr_data
);

  logic [nwta_pkg::TIME_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]            vld;
  logic [nwta_pkg::TIME_W-1:0] mem_q;
  logic                        vld_q;

  // storage array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // entries never written since reset read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= vld[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

// ----- hdl/no_wait_two_hop_slot_assigner.sv -----
// ---------------------------------------------------------------------------
// no_wait_two_hop_slot_assigner
// assigns ingress and egress start times to flows so frames never wait
// ---------------------------------------------------------------------------
// usage:
//   a request (source port, dest port, payload bytes, deadline) is taken at
//   a rising edge with start high and busy low. the result (ingress start,
//   egress start, deadline flag) is shown for one cycle with done high, in
//   the write-back state after the align state; there is no back pressure on
//   results. a new request can be taken in the cycle done is high, while the
//   last result is written back. both link time memories are read as the
//   request is taken, the hops are aligned in the align state and the new
//   free times are written in the write-back state. a request that hits a
//   link written in the cycle it is taken gets the written value forwarded.
//   configuration (switch delay, link delay, gap) is written through
//   cfg_we/cfg_index/cfg_data while no request is in flight.
//   synchronous reset clears all link free times to zero at once through
//   per-entry valid bits, and restores the register reset values.
// ---------------------------------------------------------------------------
module no_wait_two_hop_slot_assigner #(
  parameter int PORTS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  nwta_pkg::req_t                  req,
  output logic                            done,
  output nwta_pkg::resp_t                 result,
  input  logic                            cfg_we,
  input  logic [nwta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nwta_pkg::CFG_W-1:0]      cfg_data
);

  localparam int AW = $clog2(PORTS);
  localparam int TW = nwta_pkg::TIME_W;
  localparam int SW = nwta_pkg::SUM_W;

  // port code to link index, folded modulo the link count
  function automatic logic [nwta_pkg::PORT_CODES*AW-1:0] build_lut();
    logic [nwta_pkg::PORT_CODES*AW-1:0] lut;
    lut = '0;
    for (int i = 0; i < nwta_pkg::PORT_CODES; i++) begin
      lut[i*AW +: AW] = AW'(i % PORTS);
    end
    return lut;
  endfunction

  localparam logic [nwta_pkg::PORT_CODES*AW-1:0] PORT_LUT = build_lut();

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_WB   = 3'b100
  } state_t;

  state_t state, state_next;

  nwta_pkg::cfg_t cfg;

  logic                         accept;
  logic [AW-1:0]                src_idx, dst_idx;
  logic [AW-1:0]                cur_src, cur_dst;
  logic [nwta_pkg::SER_W-1:0]   ser;
  logic [SW-1:0]                d, d_next;
  logic [SW-1:0]                upd, upd_next;
  logic [SW-1:0]                hop2, hop2_next;
  logic [TW-1:0]                deadline;
  logic                         fwd_in, fwd_eg;
  logic [TW-1:0]                fwd_in_data, fwd_eg_data;
  logic [TW-1:0]                in_rd, eg_rd;
  logic [TW-1:0]                l0, l1;
  logic [TW:0]                  arrive;
  logic [TW-1:0]                ig_start, ig_start_next;
  logic [TW-1:0]                eg_start, eg_start_next;
  logic [TW:0]                  in_sum, eg_sum, check;
  logic [TW-1:0]                in_free, eg_free;
  logic                         wb;

  nwta_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // request decode
  always_comb begin
    accept  = start && !busy;
    src_idx = PORT_LUT[AW*int'(req.source_port) +: AW];
    dst_idx = PORT_LUT[AW*int'(req.dest_port) +: AW];
    ser     = nwta_pkg::SER_W'({3'b000, req.payload_bytes + nwta_pkg::HDR_BYTES}
                               << nwta_pkg::NS_SHIFT);
    d_next    = SW'(cfg.switch_delay_ns) + SW'(cfg.link_delay_ns) + SW'(ser);
    upd_next  = SW'(cfg.link_delay_ns) + SW'(ser) + SW'(cfg.gap_ns);
    hop2_next = (SW'(ser) << 1) + (SW'(cfg.link_delay_ns) << 1)
                + SW'(cfg.switch_delay_ns);
  end

  // sequencer
  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_CMP : ST_IDLE;
      ST_CMP:  state_next = ST_WB;
      ST_WB:   state_next = accept ? ST_CMP : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state == ST_CMP);
  assign wb   = (state == ST_WB);
  assign done = wb;

  // request capture, with forwarding of the write-back in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_src     <= src_idx;
      cur_dst     <= dst_idx;
      d           <= d_next;
      upd         <= upd_next;
      hop2        <= hop2_next;
      deadline    <= req.deadline_ns;
      fwd_in      <= wb && (src_idx == cur_src);
      fwd_eg      <= wb && (dst_idx == cur_dst);
      fwd_in_data <= in_free;
      fwd_eg_data <= eg_free;
    end
  end

  nwta_time_ram #(.DEPTH(PORTS), .AW(AW)) u_in_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (src_idx),
    .rd_data (in_rd),
    .wr_en   (wb),
    .wr_addr (cur_src),
    .wr_data (in_free)
  );

  nwta_time_ram #(.DEPTH(PORTS), .AW(AW)) u_eg_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (dst_idx),
    .rd_data (eg_rd),
    .wr_en   (wb),
    .wr_addr (cur_dst),
    .wr_data (eg_free)
  );

  // hop alignment: push egress later or ingress later, never wait
  always_comb begin
    l0     = fwd_in ? fwd_in_data : in_rd;
    l1     = fwd_eg ? fwd_eg_data : eg_rd;
    arrive = {1'b0, l0} + (TW+1)'(d);
    if (arrive > {1'b0, l1}) begin
      ig_start_next = l0;
      eg_start_next = arrive[TW] ? nwta_pkg::TIME_MAX : arrive[TW-1:0];
    end else begin
      ig_start_next = l1 - TW'(d);
      eg_start_next = l1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CMP) begin
      ig_start <= ig_start_next;
      eg_start <= eg_start_next;
    end
  end

  // new free times and deadline check
  always_comb begin
    in_sum  = {1'b0, ig_start} + (TW+1)'(upd);
    eg_sum  = {1'b0, eg_start} + (TW+1)'(upd);
    check   = {1'b0, ig_start} + (TW+1)'(hop2);
    in_free = in_sum[TW] ? nwta_pkg::TIME_MAX : in_sum[TW-1:0];
    eg_free = eg_sum[TW] ? nwta_pkg::TIME_MAX : eg_sum[TW-1:0];
    result.ingress_start_ns = ig_start;
    result.egress_start_ns  = eg_start;
    result.meets_deadline   = (check < {1'b0, deadline});
  end

`ifndef SYNTHESIS
  // an accepted request always leads to a busy cycle and then a result
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("request not followed by busy");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done) else $error("align cycle not followed by result");

  // a result never appears without an align cycle right before it
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without align cycle");

  // the frame cannot leave the switch before it entered
  a_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.egress_start_ns >= result.ingress_start_ns))
    else $error("egress start before ingress start");
`endif

endmodule

// ----- verif/slot_tracker_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slot_tracker_pkg
// scoreboard for the two-hop slot assigner: keeps its own copy of the link
// free times and the timing registers, works out the starts and the
// deadline flag of every accepted request and checks the results in order
// ---------------------------------------------------------------------------
package slot_tracker_pkg;

  localparam int LINKS = 32;

  class slot_tracker;
    logic [nwta_pkg::CFG_W-1:0]  switch_delay;
    logic [nwta_pkg::CFG_W-1:0]  link_delay;
    logic [nwta_pkg::CFG_W-1:0]  gap;
    logic [nwta_pkg::TIME_W-1:0] ingress_free [LINKS];
    logic [nwta_pkg::TIME_W-1:0] egress_free [LINKS];
    nwta_pkg::resp_t             expected_slots [$];
    int                          mismatch_count;

    function new();
      switch_delay   = '0;
      link_delay     = '0;
      gap            = nwta_pkg::GAP_RESET;
      mismatch_count = 0;
      for (int i = 0; i < LINKS; i++) begin
        ingress_free[i] = '0;
        egress_free[i]  = '0;
      end
    endfunction

    // out of range indexes are dropped
    function void write_reg(logic [nwta_pkg::CFG_IDX_W-1:0] index,
                            logic [nwta_pkg::CFG_W-1:0] value);
      case (index)
        nwta_pkg::CFG_SWITCH_DELAY: switch_delay = value;
        nwta_pkg::CFG_LINK_DELAY:   link_delay = value;
        nwta_pkg::CFG_GAP:          gap = value;
        default: ;
      endcase
    endfunction

    static function logic [nwta_pkg::TIME_W-1:0] clip(logic [63:0] v);
      logic [63:0] top;
      top = 64'(nwta_pkg::TIME_MAX);
      return (v > top) ? nwta_pkg::TIME_MAX : v[nwta_pkg::TIME_W-1:0];
    endfunction

    // lines up both hops at full width, link state left untouched
    function void align(input nwta_pkg::req_t r, output logic [63:0] ing_start,
                        output logic [63:0] egr_start, output logic [63:0] ser,
                        output logic [63:0] arrival);
      logic [63:0] hops;
      ser = 64'(r.payload_bytes);
      ser = (ser + 64'(nwta_pkg::HDR_BYTES)) << nwta_pkg::NS_SHIFT;
      hops = 64'(switch_delay) + 64'(link_delay) + ser;
      ing_start = 64'(ingress_free[r.source_port % LINKS]);
      egr_start = 64'(egress_free[r.dest_port % LINKS]);
      if (ing_start + hops > egr_start) begin
        egr_start = ing_start + hops;
      end else begin
        ing_start = egr_start - hops;
      end
      arrival = ing_start + (ser << 1) + (64'(link_delay) << 1) + 64'(switch_delay);
    endfunction

    function logic [63:0] arrival_of(nwta_pkg::req_t r);
      logic [63:0] ing_start, egr_start, ser, arrival;
      align(r, ing_start, egr_start, ser, arrival);
      return arrival;
    endfunction

    // request accepted: advance both links and queue the expected slots
    function void note_flow(nwta_pkg::req_t r);
      logic [63:0]     ing_start, egr_start, ser, arrival;
      nwta_pkg::resp_t slot;
      align(r, ing_start, egr_start, ser, arrival);
      ingress_free[r.source_port % LINKS] =
        clip(ing_start + 64'(link_delay) + ser + 64'(gap));
      egress_free[r.dest_port % LINKS] =
        clip(64'(clip(egr_start)) + 64'(link_delay) + ser + 64'(gap));
      slot.ingress_start_ns = clip(ing_start);
      slot.egress_start_ns  = clip(egr_start);
      slot.meets_deadline   = (arrival < 64'(r.deadline_ns));
      expected_slots = {expected_slots, slot};
    endfunction

    function int pending();
      return expected_slots.size();
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      $display("mismatch: %s", msg);
    endtask

    // compare a result with the oldest expectation, field by field
    task check_slots(nwta_pkg::resp_t got);
      nwta_pkg::resp_t want;
      if (expected_slots.size() == 0) begin
        report_mismatch($sformatf("unexpected result ingress %0d egress %0d flag %0b",
                                  got.ingress_start_ns, got.egress_start_ns,
                                  got.meets_deadline));
      end else begin
        want = expected_slots.pop_front();
        if (got.ingress_start_ns !== want.ingress_start_ns)
          report_mismatch($sformatf("ingress start got %0d want %0d",
                                    got.ingress_start_ns, want.ingress_start_ns));
        if (got.egress_start_ns !== want.egress_start_ns)
          report_mismatch($sformatf("egress start got %0d want %0d",
                                    got.egress_start_ns, want.egress_start_ns));
        if (got.meets_deadline !== want.meets_deadline)
          report_mismatch($sformatf("deadline flag got %0b want %0b",
                                    got.meets_deadline, want.meets_deadline));
      end
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives flow requests into the two-hop slot assigner under several timing
// register settings and sender idle rates, then hammers one link pair at
// the maximum timing; every result is checked against the slot tracker
// ---------------------------------------------------------------------------
module tb_top;

  localparam int PW = nwta_pkg::PORT_W;
  localparam int BW = nwta_pkg::PAYLOAD_W;
  localparam int CW = nwta_pkg::CFG_W;
  localparam int IW = nwta_pkg::CFG_IDX_W;
  localparam int TW = nwta_pkg::TIME_W;

  localparam logic [IW-1:0] CFG_UNUSED = 2'd3;
  localparam logic [CW-1:0] CFG_MAX = {CW{1'b1}};
  localparam int            CYCLE_LIMIT = 400000;
  localparam int            RANDOM_FLOWS = 200;
  localparam int            HAMMER_FLOWS = 20;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  nwta_pkg::req_t  req = '0;
  logic            done;
  nwta_pkg::resp_t result;
  logic            cfg_we = 1'b0;
  logic [IW-1:0]   cfg_index = '0;
  logic [CW-1:0]   cfg_data = '0;

  slot_tracker_pkg::slot_tracker slots;
  int                            sender_idle_pct = 7;
  int                            cycle_count = 0;

  no_wait_two_hop_slot_assigner i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // results are taken at the edge that ends their strobe cycle
  always @(posedge clk) begin
    if (!rst && done) slots.check_slots(result);
  end

  function automatic nwta_pkg::req_t make_flow(int src, int dst, int payload,
                                               logic [TW-1:0] deadline);
    nwta_pkg::req_t r;
    r.source_port   = PW'(src);
    r.dest_port     = PW'(dst);
    r.payload_bytes = BW'(payload);
    r.deadline_ns   = deadline;
    return r;
  endfunction

  function automatic logic [CW-1:0] pick_delay();
    return ($urandom_range(3) == 0) ? CW'($urandom_range(65535)) : CW'($urandom_range(2000));
  endfunction

  // one request, with random sender idle cycles ahead of it
  task automatic send_flow(input nwta_pkg::req_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    slots.note_flow(r);
  endtask

  // deadline placed margin ns from the predicted arrival
  task automatic send_flow_near(input nwta_pkg::req_t r, input int margin);
    logic [63:0] arrival;
    arrival = slots.arrival_of(r);
    if (margin < 0) begin
      arrival = arrival - 64'(-margin);
    end else begin
      arrival = arrival + 64'(margin);
    end
    r.deadline_ns = slot_tracker_pkg::slot_tracker::clip(arrival);
    send_flow(r);
  endtask

  // mostly a few busy links, now and then any link or an oversize payload
  task automatic send_random_flow();
    nwta_pkg::req_t r;
    int             mode;
    r.source_port   = ($urandom_range(9) < 6) ? PW'($urandom_range(3)) : PW'($urandom_range(31));
    r.dest_port     = ($urandom_range(9) < 6) ? PW'($urandom_range(3)) : PW'($urandom_range(31));
    r.payload_bytes = ($urandom_range(9) == 0) ? BW'($urandom_range(2047))
                                               : BW'($urandom_range(1500));
    r.deadline_ns   = $urandom;
    mode = int'($urandom_range(2));
    if (mode == 0) begin
      send_flow_near(r, int'($urandom_range(4)) - 2);
    end else if (mode == 1) begin
      send_flow_near(r, int'($urandom_range(300000)));
    end else begin
      send_flow(r);
    end
  endtask

  // keeps the write enable high so back to back writes stay one pulse train
  task automatic pulse_reg(input logic [IW-1:0] index, input logic [CW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    slots.write_reg(index, value);
  endtask

  task automatic set_timing(input logic [CW-1:0] sw, input logic [CW-1:0] ld,
                            input logic [CW-1:0] gp);
    pulse_reg(CFG_UNUSED, CW'($urandom));
    pulse_reg(nwta_pkg::CFG_SWITCH_DELAY, sw);
    pulse_reg(nwta_pkg::CFG_LINK_DELAY, ld);
    pulse_reg(nwta_pkg::CFG_GAP, gp);
    cfg_we <= 1'b0;
  endtask

  // drain every outstanding request, then a short pause for the pipeline
  task automatic settle();
    start <= 1'b0;
    while (slots.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    slots = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset timing: edge payloads, back to back on the same links
    send_flow(make_flow(0, 0, 0, 32'd0));
    send_flow(make_flow(31, 31, 1500, nwta_pkg::TIME_MAX));
    send_flow_near(make_flow(31, 31, 2047, 32'd0), 0);
    send_flow_near(make_flow(31, 30, 1, 32'd0), 1);
    // idle ingress behind a busy egress: ingress shifted later
    send_flow_near(make_flow(2, 31, 64, 32'd0), -1);
    send_flow(make_flow(30, 2, 700, $urandom));
    send_flow(make_flow(2, 2, 0, nwta_pkg::TIME_MAX));

    // everything zero, including the gap
    settle();
    set_timing('0, '0, '0);
    send_flow(make_flow(5, 6, 0, nwta_pkg::TIME_MAX));
    send_flow(make_flow(5, 6, 0, 32'h0000_ffff));
    send_flow_near(make_flow(6, 5, 1500, 32'd0), 0);
    send_flow(make_flow(16, 15, 1024, 32'h8000_0000));

    // everything at its maximum
    settle();
    set_timing(CFG_MAX, CFG_MAX, CFG_MAX);
    send_flow_near(make_flow(0, 31, 2047, 32'd0), 0);
    send_flow_near(make_flow(0, 31, 2047, 32'd0), 1);
    send_flow(make_flow(31, 0, 0, nwta_pkg::TIME_MAX));
    send_flow(make_flow(21, 10, 1500, 32'h5555_5555));
    send_flow(make_flow(10, 21, 1023, 32'haaaa_aaaa));

    // random phases: light, heavy and no sender idling
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      set_timing(pick_delay(), pick_delay(), pick_delay());
      sender_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 70 : 0;
      repeat (RANDOM_FLOWS) send_random_flow();
    end

    // hammer one link pair back to back at the maximum timing
    settle();
    set_timing(CFG_MAX, CFG_MAX, CFG_MAX);
    sender_idle_pct = 0;
    repeat (HAMMER_FLOWS) send_flow(make_flow(0, 0, 2047, $urandom));
    repeat (20) send_random_flow();

    settle();
    repeat (4) @(posedge clk);
    if (slots.mismatch_count == 0 && slots.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- no_wait_two_hop_slot_assigner.f -----
hdl/nwta_pkg.sv
hdl/nwta_cfg_regs.sv
hdl/nwta_time_ram.sv
hdl/no_wait_two_hop_slot_assigner.sv
verif/slot_tracker_pkg.sv
verif/tb_top.sv
